>>> rtl/hash_set_linear_probe_defines.svh
// Assertion macros shared by the hash set RTL.
`ifndef HASH_SET_LINEAR_PROBE_DEFINES_SVH
`define HASH_SET_LINEAR_PROBE_DEFINES_SVH
`ifndef SYNTH
`define HSLP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hslp assertion failed");
`define HSLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (!reset && (ante)) |=> (cons)) else $error("hslp assertion failed");
`else
`define HSLP_ASSERT_IMPL(label, ante, cons)
`define HSLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/hslp_pkg.sv
// Types, constants and sizes shared by the hash set modules.
`timescale 1ns / 1ps
package hslp_pkg;

   localparam int LOG2_SLOTS = 10;
   localparam int SLOTS      = 1 << LOG2_SLOTS;
   localparam int KEY_W      = 64;
   localparam int HALF_W     = KEY_W / 2;
   localparam int COUNT_W    = 11;
   localparam int CNT_W      = (LOG2_SLOTS + 1 > COUNT_W) ? LOG2_SLOTS + 1 : COUNT_W;
   // Smallest count c with c * 10 >= SLOTS * 7; an insert is refused when count + 1 reaches it.
   localparam int LIMIT      = (SLOTS * 7 + 9) / 10;

   localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
   localparam int SHIFT_PRE  = 30;
   localparam int SHIFT_MID  = 27;
   localparam int SHIFT_POST = 31;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1_LL,
      ST_MUL1_HL,
      ST_MUL1_LH,
      ST_MIX1,
      ST_MUL2_LL,
      ST_MUL2_HL,
      ST_MUL2_LH,
      ST_MIX2,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LL,
      MUL_HL,
      MUL_LH
   } mul_phase_type;

   typedef struct packed {
      logic          clear;
      logic          load;
      mul_phase_type mul_phase;
      logic          mul_second;
      logic          mix_first;
      logic          mix_second;
      logic          read;
      logic          step;
      logic          write;
      logic          finish;
      logic          res_found;
      logic          res_inserted;
      logic          res_status;
      logic          emit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic key_zero;
      logic is_insert;
      logic hit;
      logic empty;
      logic last_probe;
      logic at_limit;
      logic out_free;
   } dp_sts_type;

endpackage

>>> rtl/hslp_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface hslp_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [hslp_pkg::KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink (input valid, input opcode, input key, output ready);
endinterface

interface hslp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic                         inserted;
   logic                         status;
   logic [hslp_pkg::COUNT_W-1:0] member_count;

   modport source (output valid, output found, output inserted, output status,
                   output member_count, input ready);
   modport sink (input valid, input found, input inserted, input status,
                 input member_count, output ready);
endinterface

>>> rtl/hslp_ctrl.sv
// Controller state machine that sequences hashing, probing and responses.
`timescale 1ns / 1ps
`include "hash_set_linear_probe_defines.svh"
module hslp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   output logic                   req_ready,
   output hslp_pkg::dp_cmd_type   cmd,
   input  hslp_pkg::dp_sts_type   sts
);
   import hslp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) state_in = ST_MUL1_LL;
         end
         ST_MUL1_LL: begin
            state_in = sts.key_zero ? ST_DONE : ST_MUL1_HL;
         end
         ST_MUL1_HL: state_in = ST_MUL1_LH;
         ST_MUL1_LH: state_in = ST_MIX1;
         ST_MIX1:    state_in = ST_MUL2_LL;
         ST_MUL2_LL: state_in = ST_MUL2_HL;
         ST_MUL2_HL: state_in = ST_MUL2_LH;
         ST_MUL2_LH: state_in = ST_MIX2;
         ST_MIX2:    state_in = ST_READ;
         ST_READ:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.hit || sts.empty || sts.last_probe) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_accept;
         end
         ST_MUL1_LL: begin
            cmd.mul_phase = MUL_LL;
            // A zero key is never a member, so it is answered without a probe.
            cmd.finish    = sts.key_zero;
         end
         ST_MUL1_HL: cmd.mul_phase = MUL_HL;
         ST_MUL1_LH: cmd.mul_phase = MUL_LH;
         ST_MIX1:    cmd.mix_first = 1'b1;
         ST_MUL2_LL: begin
            cmd.mul_phase  = MUL_LL;
            cmd.mul_second = 1'b1;
         end
         ST_MUL2_HL: begin
            cmd.mul_phase  = MUL_HL;
            cmd.mul_second = 1'b1;
         end
         ST_MUL2_LH: begin
            cmd.mul_phase  = MUL_LH;
            cmd.mul_second = 1'b1;
         end
         ST_MIX2: cmd.mix_second = 1'b1;
         ST_READ: cmd.read = 1'b1;
         ST_CHECK: begin
            if (sts.hit) begin
               cmd.finish    = 1'b1;
               cmd.res_found = 1'b1;
            end else if (sts.empty) begin
               cmd.finish = 1'b1;
               if (sts.is_insert && !sts.at_limit) begin
                  cmd.write        = 1'b1;
                  cmd.res_inserted = 1'b1;
               end else begin
                  cmd.res_status = sts.is_insert;
               end
            end else if (sts.last_probe) begin
               // Every slot was visited without a stop: the key is absent.
               cmd.finish     = 1'b1;
               cmd.res_status = sts.is_insert;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: cmd.emit = sts.out_free;
         default: cmd = '0;
      endcase
   end

   `HSLP_ASSERT_IMPL(a_emit_needs_room, cmd.emit, sts.out_free)
   `HSLP_ASSERT_NEXT(a_finish_then_done, cmd.finish, state_ff == ST_DONE)
   `HSLP_ASSERT_NEXT(a_emit_then_idle, cmd.emit, state_ff == ST_IDLE && req_ready)

endmodule

>>> rtl/hslp_dp.sv
// Datapath: key hash with a shared multiplier, slot memory, counters and response register.
`timescale 1ns / 1ps
`include "hash_set_linear_probe_defines.svh"
module hslp_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_opcode,
   input  logic [hslp_pkg::KEY_W-1:0]     req_key,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic                           rsp_inserted,
   output logic                           rsp_status,
   output logic [hslp_pkg::COUNT_W-1:0]   rsp_member_count,
   input  hslp_pkg::dp_cmd_type           cmd,
   output hslp_pkg::dp_sts_type           sts
);
   import hslp_pkg::*;

   logic [KEY_W-1:0]      slot_mem [SLOTS];
   logic [KEY_W-1:0]      rd_data_ff;

   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      z_ff;
   logic [KEY_W-1:0]      acc_ff;
   logic [LOG2_SLOTS-1:0] idx_ff;
   logic [LOG2_SLOTS-1:0] probe_cnt_ff;
   logic [LOG2_SLOTS-1:0] clr_addr_ff;
   logic [CNT_W-1:0]      count_ff;

   logic                  res_found_ff;
   logic                  res_inserted_ff;
   logic                  res_status_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic                  rsp_inserted_ff;
   logic                  rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [HALF_W-1:0]     mul_a;
   logic [HALF_W-1:0]     mul_b;
   logic [KEY_W-1:0]      mul_const;
   logic [KEY_W-1:0]      prod;
   logic [KEY_W-1:0]      mix_mid;
   logic [KEY_W-1:0]      mix_post;

   // One 32x32 multiplier builds the low 64 bits of z * C over three phases:
   // low x low, then the two cross terms folded into the upper half.
   assign mul_const = cmd.mul_second ? MIX_C2 : MIX_C1;

   always_comb begin
      case (cmd.mul_phase)
         MUL_HL: begin
            mul_a = z_ff[KEY_W-1:HALF_W];
            mul_b = mul_const[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = z_ff[HALF_W-1:0];
            mul_b = mul_const[KEY_W-1:HALF_W];
         end
         default: begin
            mul_a = z_ff[HALF_W-1:0];
            mul_b = mul_const[HALF_W-1:0];
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign mix_mid  = acc_ff ^ (acc_ff >> SHIFT_MID);
   assign mix_post = acc_ff ^ (acc_ff >> SHIFT_POST);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         z_ff   <= req_key ^ (req_key >> SHIFT_PRE);
      end else if (cmd.mix_first) begin
         z_ff <= mix_mid;
      end

      case (cmd.mul_phase)
         MUL_LL: acc_ff <= prod;
         MUL_HL, MUL_LH: begin
            acc_ff[KEY_W-1:HALF_W] <= acc_ff[KEY_W-1:HALF_W] + prod[HALF_W-1:0];
         end
         default: acc_ff <= acc_ff;
      endcase

      if (cmd.mix_second) begin
         idx_ff       <= mix_post[LOG2_SLOTS-1:0];
         probe_cnt_ff <= '0;
      end else if (cmd.step) begin
         idx_ff       <= idx_ff + LOG2_SLOTS'(1);
         probe_cnt_ff <= probe_cnt_ff + LOG2_SLOTS'(1);
      end

      if (cmd.finish) begin
         res_found_ff    <= cmd.res_found;
         res_inserted_ff <= cmd.res_inserted;
         res_status_ff   <= cmd.res_status;
      end

      if (cmd.emit) begin
         rsp_found_ff    <= res_found_ff;
         rsp_inserted_ff <= res_inserted_ff;
         rsp_status_ff   <= res_status_ff;
         rsp_count_ff    <= count_ff[COUNT_W-1:0];
      end
   end

   // Slot memory: one write port shared by the clearing pass and inserts, one read port.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         slot_mem[clr_addr_ff] <= '0;
      end else if (cmd.write) begin
         slot_mem[idx_ff] <= key_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= slot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + LOG2_SLOTS'(1);
         if (cmd.write) count_ff <= count_ff + CNT_W'(1);
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (clr_addr_ff == '1);
      sts.key_zero   = (key_ff == '0);
      sts.is_insert  = op_ff;
      sts.hit        = (rd_data_ff == key_ff);
      sts.empty      = (rd_data_ff == '0);
      sts.last_probe = (probe_cnt_ff == '1);
      sts.at_limit   = (count_ff >= CNT_W'(LIMIT - 1));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_inserted     = rsp_inserted_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_member_count = rsp_count_ff;

   `HSLP_ASSERT_IMPL(a_count_below_limit, 1'b1, count_ff < CNT_W'(LIMIT))
   `HSLP_ASSERT_NEXT(a_write_counts, cmd.write, count_ff == $past(count_ff) + CNT_W'(1))
   `HSLP_ASSERT_NEXT(a_rsp_held, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule

>>> rtl/hash_set_linear_probe.sv
// Top level of the linear-probing hash set.
//
//   channel  direction  payload                                     transaction
//   req_ch   in         opcode, key                                 valid && ready
//   rsp_ch   out        found, inserted, status, member_count       valid && ready
//
// An accepted item passes the hash states, then a read and a compare state per probed slot,
// then the done state that loads the response; a zero key skips from the first hash state
// to done. A new request is taken only once the response is loaded. Hashing shares one
// 32x32 multiplier, and probing uses the single read port of the slot memory. After reset
// a clearing pass zeroes all SLOTS slots (1024 at the default size) and no request is taken
// until it ends. A waiting response does not block acceptance; only a second one waits.
`timescale 1ns / 1ps
module hash_set_linear_probe (
   input  logic       clock,
   input  logic       reset,
   hslp_req_if.sink   req_ch,
   hslp_rsp_if.source rsp_ch
);
   import hslp_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;
   logic       req_accept;

   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;

   hslp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   hslp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_ch.opcode),
      .req_key          (req_ch.key),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_found        (rsp_ch.found),
      .rsp_inserted     (rsp_ch.inserted),
      .rsp_status       (rsp_ch.status),
      .rsp_member_count (rsp_ch.member_count),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
